// ===== src/gbt_pkg.sv =====
// Package for the graph traversal unit: sizes, codes and the controller/datapath links.
// Used by gbt_ctrl, gbt_datapath and graph_bfs_dfs_traversal_unit; depends on nothing.
package gbt_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int MAX_DEGREE   = 8;
  localparam int STORE_DEPTH  = MAX_VERTICES * MAX_DEGREE;
  localparam int WORK_DEPTH   = STORE_DEPTH;

  localparam int VTX_W      = 4;                         // vertex field width
  localparam int DEG_W      = $clog2(MAX_DEGREE + 1);    // holds 0..MAX_DEGREE
  localparam int STORE_AW   = $clog2(STORE_DEPTH);
  localparam int WORK_AW    = $clog2(WORK_DEPTH);
  localparam int WORK_PW    = $clog2(WORK_DEPTH + 1);    // pointer holds the depth itself
  localparam int CNT_W      = 5;                         // vertex_count register
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAV_MODE    = 1'b1;

  localparam logic OP_ADD_EDGE = 1'b0;
  localparam logic OP_TRAVERSE = 1'b1;
  localparam logic MODE_BFS    = 1'b0;
  localparam logic MODE_DFS    = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } gbt_status_e;

  typedef enum logic [1:0] {
    DEG_A,
    DEG_B,
    DEG_NODE
  } gbt_deg_sel_e;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_STATUS,
    EMIT_FINAL
  } gbt_emit_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE_DA,
    S_EDGE_DB,
    S_EDGE_CHK,
    S_EDGE_WA,
    S_EDGE_WB,
    S_RESP,
    S_TRAV_INIT,
    S_POP,
    S_NODE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FINAL
  } gbt_state_e;

  typedef struct packed {
    logic         latch_in;
    gbt_deg_sel_e deg_sel;
    logic         latch_dega;
    logic         latch_degb;
    logic         edge_write;
    logic         trav_init;
    logic         pop;
    logic         node_load;
    logic         visit;
    logic         scan_rd;
    logic         scan_chk;
    gbt_emit_e    emit;
  } gbt_cmd_t;

  typedef struct packed {
    logic mode;
    logic root_bad;
    logic edge_ok;
    logic list_empty;
    logic node_seen;
    logic pend_valid;
    logic scan_done;
    logic out_free;
  } gbt_sts_t;

endpackage

// ===== src/gbt_ctrl.sv =====
// Sequencer for edge insertion and BFS/DFS walks.
// Depends on gbt_pkg; drives gbt_datapath through gbt_cmd_t, reads gbt_sts_t.
module gbt_ctrl
  import gbt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_op_i,
  output logic     in_ready_o,
  input  gbt_sts_t sts_i,
  output gbt_cmd_t cmd_o
);

  gbt_state_e state_q, state_d;
  logic       visit_needed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // BFS reports every popped vertex; DFS only on first pop
  assign visit_needed = (sts_i.mode == MODE_BFS) || !sts_i.node_seen;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.emit = EMIT_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = (in_op_i == OP_ADD_EDGE) ? S_EDGE_DA : S_TRAV_INIT;
        end
      end
      S_EDGE_DA: begin
        cmd_o.deg_sel    = DEG_A;
        cmd_o.latch_dega = 1'b1;
        state_d          = S_EDGE_DB;
      end
      S_EDGE_DB: begin
        cmd_o.deg_sel    = DEG_B;
        cmd_o.latch_degb = 1'b1;
        state_d          = S_EDGE_CHK;
      end
      S_EDGE_CHK: begin
        state_d = sts_i.edge_ok ? S_EDGE_WA : S_RESP;
      end
      S_EDGE_WA: begin
        cmd_o.deg_sel    = DEG_A;
        cmd_o.edge_write = 1'b1;
        state_d          = S_EDGE_WB;
      end
      S_EDGE_WB: begin
        cmd_o.deg_sel    = DEG_B;
        cmd_o.edge_write = 1'b1;
        state_d          = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.emit = EMIT_STATUS;
          state_d    = S_IDLE;
        end
      end
      S_TRAV_INIT: begin
        if (sts_i.root_bad) begin
          state_d = S_RESP;
        end else begin
          cmd_o.trav_init = 1'b1;
          state_d         = S_POP;
        end
      end
      S_POP: begin
        if (sts_i.list_empty) begin
          state_d = S_FINAL;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = S_NODE;
        end
      end
      S_NODE: begin
        // hold while a pending result cannot be pushed out
        if (!(visit_needed && sts_i.pend_valid && !sts_i.out_free)) begin
          cmd_o.node_load = 1'b1;
          cmd_o.visit     = visit_needed;
          state_d         = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd_o.deg_sel = DEG_NODE;
        if (sts_i.scan_done) begin
          state_d = S_POP;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d       = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        cmd_o.scan_chk = 1'b1;
        state_d        = S_SCAN_RD;
      end
      S_FINAL: begin
        if (sts_i.out_free) begin
          cmd_o.emit = EMIT_FINAL;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/gbt_datapath.sv =====
// Datapath: config registers, degree counters, neighbour and work-list memories,
// visited map and the output register. Depends on gbt_pkg.
module gbt_datapath
  import gbt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_op_i,
  input  logic [VTX_W-1:0]      in_node_a_i,
  input  logic [VTX_W-1:0]      in_node_b_i,
  input  gbt_cmd_t              cmd_i,
  output gbt_sts_t              sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [VTX_W-1:0]      out_vertex_o,
  output logic [STATUS_W-1:0]   out_status_o,
  output logic                  out_last_o
);

  function automatic logic [STORE_AW-1:0] store_addr(input logic [VTX_W-1:0] v,
                                                     input logic [DEG_W-1:0] j);
    store_addr = STORE_AW'(v) * STORE_AW'(MAX_DEGREE) + STORE_AW'(j);
  endfunction

  // configuration
  logic [CNT_W-1:0] vcount_q;
  logic             mode_q;
  logic [CNT_W-1:0] limit;

  // latched item
  logic             op_q;
  logic [VTX_W-1:0] a_q, b_q;

  // degrees
  logic [DEG_W-1:0] deg_q [MAX_VERTICES];
  logic [DEG_W-1:0] dega_q, degb_q;
  logic [VTX_W-1:0] deg_addr;
  logic [DEG_W-1:0] deg_rd;
  logic [DEG_W:0]   dega_p2;

  // memories
  logic [VTX_W-1:0]    store_mem [STORE_DEPTH];
  logic [VTX_W-1:0]    store_rdata_q;
  logic [STORE_AW-1:0] store_waddr, store_raddr;
  logic [VTX_W-1:0]    store_wdata;

  logic [VTX_W-1:0]   work_mem [WORK_DEPTH];
  logic [VTX_W-1:0]   work_rdata_q;
  logic               work_we;
  logic [WORK_AW-1:0] work_waddr, work_raddr;
  logic [VTX_W-1:0]   work_wdata;
  logic [WORK_PW-1:0] head_q, tail_q, tail_dec;
  logic               push_ok, n_unseen;

  // walk state
  logic [MAX_VERTICES-1:0] visited_q, visited_d;
  logic [VTX_W-1:0]        node_q, pend_q;
  logic                    pend_valid_q;
  logic [DEG_W-1:0]        j_q;

  // status
  logic        range_bad, root_bad, full_bad;
  gbt_status_e edge_st, resp_st;

  // output register
  logic                out_valid_q;
  logic [VTX_W-1:0]    out_vertex_q;
  logic [STATUS_W-1:0] out_status_q;
  logic                out_last_q;
  logic                out_free, out_load;

  assign limit = (vcount_q > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vcount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= CNT_W'(16);
      mode_q   <= MODE_BFS;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_VERTEX_COUNT: vcount_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_TRAV_MODE:    mode_q   <= cfg_wdata_i[0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q <= in_op_i;
      a_q  <= in_node_a_i;
      b_q  <= in_node_b_i;
    end
    if (cmd_i.latch_dega) dega_q <= deg_rd;
    if (cmd_i.latch_degb) degb_q <= deg_rd;
  end

  // degree table, one read port chosen by the sequencer
  always_comb begin
    case (cmd_i.deg_sel)
      DEG_A:    deg_addr = a_q;
      DEG_B:    deg_addr = b_q;
      DEG_NODE: deg_addr = node_q;
      default:  deg_addr = a_q;
    endcase
  end
  assign deg_rd = deg_q[deg_addr];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_VERTICES; i++) deg_q[i] <= '0;
    end else if (cmd_i.edge_write) begin
      deg_q[deg_addr] <= deg_rd + DEG_W'(1);
    end
  end

  // edge checks
  assign range_bad = ({1'b0, a_q} >= limit) || ({1'b0, b_q} >= limit);
  assign root_bad  = {1'b0, a_q} >= limit;
  assign dega_p2   = {1'b0, dega_q} + (DEG_W+1)'(2);
  assign full_bad  = (a_q == b_q) ? (dega_p2 > (DEG_W+1)'(MAX_DEGREE))
                                  : ((dega_q >= DEG_W'(MAX_DEGREE)) ||
                                     (degb_q >= DEG_W'(MAX_DEGREE)));
  assign edge_st   = range_bad ? ST_RANGE : (full_bad ? ST_FULL : ST_OK);
  assign resp_st   = (op_q == OP_TRAVERSE) ? ST_RANGE : edge_st;

  // neighbour store: edge append writes, scan reads
  assign store_waddr = store_addr(deg_addr, deg_rd);
  assign store_wdata = (cmd_i.deg_sel == DEG_A) ? b_q : a_q;
  assign store_raddr = store_addr(node_q, j_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.edge_write) store_mem[store_waddr] <= store_wdata;
    if (cmd_i.scan_rd)    store_rdata_q <= store_mem[store_raddr];
  end

  // work list: FIFO from head in BFS, stack at tail in DFS
  assign n_unseen   = !visited_q[store_rdata_q];
  assign push_ok    = cmd_i.scan_chk && n_unseen && (tail_q < WORK_PW'(WORK_DEPTH));
  assign tail_dec   = tail_q - WORK_PW'(1);
  assign work_we    = cmd_i.trav_init || push_ok;
  assign work_waddr = cmd_i.trav_init ? '0 : tail_q[WORK_AW-1:0];
  assign work_wdata = cmd_i.trav_init ? a_q : store_rdata_q;
  assign work_raddr = (mode_q == MODE_BFS) ? head_q[WORK_AW-1:0] : tail_dec[WORK_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (work_we)   work_mem[work_waddr] <= work_wdata;
    if (cmd_i.pop) work_rdata_q <= work_mem[work_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else if (cmd_i.trav_init) begin
      head_q <= '0;
      tail_q <= WORK_PW'(1);
    end else if (cmd_i.pop) begin
      if (mode_q == MODE_BFS) head_q <= head_q + WORK_PW'(1);
      else                    tail_q <= tail_dec;
    end else if (push_ok) begin
      tail_q <= tail_q + WORK_PW'(1);
    end
  end

  // visited map: BFS marks on enqueue, DFS on first pop
  always_comb begin
    visited_d = visited_q;
    if (cmd_i.trav_init) begin
      visited_d = '0;
      if (mode_q == MODE_BFS) visited_d[a_q] = 1'b1;
    end
    if (cmd_i.visit) visited_d[work_rdata_q] = 1'b1;
    if (cmd_i.scan_chk && n_unseen && (mode_q == MODE_BFS)) visited_d[store_rdata_q] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q    <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      visited_q <= visited_d;
      if (cmd_i.trav_init)  pend_valid_q <= 1'b0;
      else if (cmd_i.visit) pend_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.node_load) begin
      node_q <= work_rdata_q;
      j_q    <= '0;
    end else if (cmd_i.scan_chk) begin
      j_q <= j_q + DEG_W'(1);
    end
    if (cmd_i.visit) pend_q <= work_rdata_q;
  end

  // output register; one visit behind so the final vertex can carry last
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (cmd_i.emit != EMIT_NONE) || (cmd_i.visit && pend_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      case (cmd_i.emit)
        EMIT_STATUS: begin
          out_vertex_q <= '0;
          out_status_q <= resp_st;
          out_last_q   <= 1'b1;
        end
        EMIT_FINAL: begin
          out_vertex_q <= pend_q;
          out_status_q <= ST_OK;
          out_last_q   <= 1'b1;
        end
        default: begin
          out_vertex_q <= pend_q;
          out_status_q <= ST_OK;
          out_last_q   <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_vertex_o = out_vertex_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

  assign sts_o.mode       = mode_q;
  assign sts_o.root_bad   = root_bad;
  assign sts_o.edge_ok    = (edge_st == ST_OK);
  assign sts_o.list_empty = (mode_q == MODE_BFS) ? (head_q == tail_q) : (tail_q == '0);
  assign sts_o.node_seen  = visited_q[work_rdata_q];
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.scan_done  = (j_q >= deg_rd) || (j_q >= DEG_W'(MAX_DEGREE));
  assign sts_o.out_free   = out_free;

endmodule

// ===== src/graph_bfs_dfs_traversal_unit.sv =====
// Top level of the graph traversal unit: stream ports, config port, assertions.
// Depends on gbt_pkg, gbt_ctrl and gbt_datapath.
//
// Usage notes
// - Input stream (s_axis_*): one word per command. tuser = operation (0 add an
//   undirected edge, 1 traverse from root); tdata carries node_a and node_b.
// - Output stream (m_axis_*): an add-edge word answers with one word (vertex 0,
//   status). A traversal gives one word per vertex in visit order, tlast on the
//   final one; a bad root gives a single status word with tlast.
// - Config: cfg_we_i writes vertex_count (index 0) or traversal_mode (index 1,
//   0 breadth-first, 1 depth-first); write only while the unit is idle.
// - Timing: one command at a time. An edge add passes the degree reads of both
//   nodes and the check, then the writes for both ends if it is stored, before its
//   status word is loaded; the next word is taken once the unit is back in idle. A
//   walk pops a vertex, loads it and scans its neighbour entries, each one a read
//   and a check, paced by the registered neighbour store read, with set-up first and
//   wrap-up last. Depth-first can pop a vertex several times, rescanning its list on each pop.
// - The output register decouples the sides: a new word may be accepted while
//   the last result waits; a stalled receiver halts the walk at the next visit.
// - Reset clears degrees, visited map and pointers and restores vertex_count 16,
//   breadth-first mode; neighbour entries are only read below a vertex's degree.
module graph_bfs_dfs_traversal_unit
  import gbt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [3:0] node_a, [7:4] node_b
  input  logic                  s_axis_tuser,   // [0] operation
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // [3:0] vertex, [5:4] status, [7:6] zero
  output logic                  m_axis_tlast,   // last word of this command
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  gbt_cmd_t            cmd;
  gbt_sts_t            sts;
  logic [VTX_W-1:0]    out_vertex;
  logic [STATUS_W-1:0] out_status;

  gbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gbt_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_op_i      (s_axis_tuser),
    .in_node_a_i  (s_axis_tdata[3:0]),
    .in_node_b_i  (s_axis_tdata[7:4]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_vertex_o (out_vertex),
    .out_status_o (out_status),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_status, out_vertex};

  // one command in flight: accepting a word leaves the idle state
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word accepted while a command is in progress");

  // results are only loaded when the output register can take them
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit != EMIT_NONE) || (cmd.visit && sts.pend_valid) |-> sts.out_free)
    else $error("output register overwritten while held");

  // no result is produced while waiting for a new command
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (cmd.emit == EMIT_NONE) && !cmd.visit)
    else $error("result emitted from the idle state");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[5:4] != 2'd3))
    else $error("undefined status code on output");

endmodule
